>>> src/blinn_phong_specular_shader_core_assert.svh
// Assertion macros for the specular shader core.
`ifndef BLINN_PHONG_SPECULAR_SHADER_CORE_ASSERT_SVH
`define BLINN_PHONG_SPECULAR_SHADER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bps: same-cycle check failed");
`define BPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bps: next-cycle check failed");
`else
`define BPS_ASSERT_IMP(lbl, ante, cons)
`define BPS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/bps_pkg.sv
`default_nettype none

package bps_pkg;

	localparam int POW_TABLE_BITS = 8;
	localparam int TBL_SIZE = 1 << POW_TABLE_BITS;

	localparam int SQ_STEPS = 27;
	localparam int SQ_W = 2 * SQ_STEPS + 1;
	localparam int DIV_STEPS = 16;
	localparam int DIV_W = 45;

	localparam logic [16:0] ONE_Q16 = 17'h10000;
	// ceil(2^33 / 255): exact floor(x / 255) for x below 2^25
	localparam logic [25:0] RECIP_255 = 26'd33686019;

	typedef struct packed {
		logic        zero;
		logic [15:0] strength;
		logic [15:0] exponent;
		logic [23:0] rgb;
	} side_t;

	typedef logic [15:0] lg_tab_t [TBL_SIZE];
	typedef logic [16:0] ex_tab_t [TBL_SIZE];

	function automatic longint unsigned isqrt64(input longint unsigned x);
		longint unsigned v;
		longint unsigned r;
		longint unsigned b;
		v = x;
		r = 64'd0;
		for (int k = 0; k < 32; k++) begin
			b = 64'd1 << (62 - 2 * k);
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

	// log2(1 + i/2^B) in Q0.16 by repeated squaring of a Q1.30 mantissa
	function automatic lg_tab_t build_lg();
		lg_tab_t tab;
		longint unsigned y;
		logic [15:0] r;
		for (int i = 0; i < TBL_SIZE; i++) begin
			y = 64'(TBL_SIZE + i) << (30 - POW_TABLE_BITS);
			r = '0;
			for (int k = 0; k < 16; k++) begin
				y = (y * y) >> 30;
				r = {r[14:0], 1'b0};
				if (y >= (64'd1 << 31)) begin
					r[0] = 1'b1;
					y = y >> 1;
				end
			end
			tab[i] = r;
		end
		return tab;
	endfunction

	// 2^(-j/2^B) in Q1.16 from a product of Q0.32 roots of one half
	function automatic ex_tab_t build_ex();
		ex_tab_t tab;
		longint unsigned roots [POW_TABLE_BITS + 1];
		longint unsigned v;
		roots[0] = 64'd0;
		roots[1] = isqrt64(64'd1 << 63);
		for (int k = 2; k <= POW_TABLE_BITS; k++) begin
			roots[k] = isqrt64(roots[k - 1] << 32);
		end
		for (int i = 0; i < TBL_SIZE; i++) begin
			v = 64'd1 << 32;
			for (int k = 1; k <= POW_TABLE_BITS; k++) begin
				if (((i >> (POW_TABLE_BITS - k)) & 1) != 0) begin
					v = (v * roots[k]) >> 32;
				end
			end
			tab[i] = 17'((v + 64'd32768) >> 16);
		end
		return tab;
	endfunction

	localparam lg_tab_t LG_TAB = build_lg();
	localparam ex_tab_t EX_TAB = build_ex();

endpackage

`default_nettype wire

>>> src/blinn_phong_specular_shader_core.sv
// Pipeline from input transfer to result (3 vector, 27 root, 17 divide, 7 power stages).
// Throughput: one item per cycle; every stage is a register and the whole pipe
// advances together, holding while a finished result is stalled at the output.
// Reset: arst_n clears all valid bits at once; payload registers are not reset.
`default_nettype none

`include "blinn_phong_specular_shader_core_assert.svh"

module blinn_phong_specular_shader_core
	import bps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] light_dir_x,
	input  logic signed [15:0] light_dir_y,
	input  logic signed [15:0] light_dir_z,
	input  logic signed [15:0] view_dir_x,
	input  logic signed [15:0] view_dir_y,
	input  logic signed [15:0] view_dir_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic        [15:0] spec_strength,
	input  logic        [15:0] spec_exponent,
	input  logic        [23:0] light_rgb,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [15:0] add_red,
	output logic        [15:0] add_green,
	output logic        [15:0] add_blue
);

	logic               adv;
	logic               fr_valid, sq_valid, dv_valid;
	logic        [33:0] fr_m2;
	logic signed [33:0] fr_d, sq_d;
	logic        [26:0] sq_root;
	logic        [16:0] dv_cos;
	side_t              fr_side, sq_side, dv_side;

	// Hold the whole pipe while the output register waits
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	bps_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (in_valid),
		.light_dir_x   (light_dir_x),
		.light_dir_y   (light_dir_y),
		.light_dir_z   (light_dir_z),
		.view_dir_x    (view_dir_x),
		.view_dir_y    (view_dir_y),
		.view_dir_z    (view_dir_z),
		.normal_x      (normal_x),
		.normal_y      (normal_y),
		.normal_z      (normal_z),
		.spec_strength (spec_strength),
		.spec_exponent (spec_exponent),
		.light_rgb     (light_rgb),
		.fr_valid      (fr_valid),
		.fr_m2         (fr_m2),
		.fr_d          (fr_d),
		.fr_side       (fr_side)
	);

	bps_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (fr_valid),
		.m2       (fr_m2),
		.d        (fr_d),
		.side     (fr_side),
		.sq_valid (sq_valid),
		.sq_root  (sq_root),
		.sq_d     (sq_d),
		.sq_side  (sq_side)
	);

	bps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (sq_valid),
		.root     (sq_root),
		.d        (sq_d),
		.side     (sq_side),
		.dv_valid (dv_valid),
		.dv_cos   (dv_cos),
		.dv_side  (dv_side)
	);

	bps_pow u_pow (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (dv_valid),
		.cos       (dv_cos),
		.side      (dv_side),
		.out_valid (out_valid),
		.add_red   (add_red),
		.add_green (add_green),
		.add_blue  (add_blue)
	);

	`BPS_ASSERT_NEXT(a_pipe_frozen, out_valid && out_stall, $stable(sq_valid) && $stable(dv_valid))
	`BPS_ASSERT_IMP(a_zero_half_cos, dv_valid && dv_side.zero, dv_cos == 17'd0)

endmodule

`default_nettype wire

>>> src/bps_front.sv
`default_nettype none

module bps_front
	import bps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic signed [15:0] light_dir_x,
	input  logic signed [15:0] light_dir_y,
	input  logic signed [15:0] light_dir_z,
	input  logic signed [15:0] view_dir_x,
	input  logic signed [15:0] view_dir_y,
	input  logic signed [15:0] view_dir_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic        [15:0] spec_strength,
	input  logic        [15:0] spec_exponent,
	input  logic        [23:0] light_rgb,
	output logic               fr_valid,
	output logic        [33:0] fr_m2,
	output logic signed [33:0] fr_d,
	output side_t              fr_side
);

	logic               vld_s1, vld_s2, vld_s3;
	logic signed [16:0] hx_s1, hy_s1, hz_s1;
	logic signed [15:0] nx_s1, ny_s1, nz_s1;
	side_t              side_s1, side_s2, side_s3;

	logic        [31:0] sqx_s2, sqy_s2, sqz_s2;
	logic signed [31:0] dx_s2, dy_s2, dz_s2;

	logic        [33:0] m2_s3;
	logic signed [33:0] d_s3;

	logic signed [33:0] px, py, pz;
	logic signed [32:0] qx, qy, qz;
	logic        [33:0] m2_sum;
	logic signed [33:0] d_sum;

	assign px = hx_s1 * hx_s1;
	assign py = hy_s1 * hy_s1;
	assign pz = hz_s1 * hz_s1;
	assign qx = hx_s1 * nx_s1;
	assign qy = hy_s1 * ny_s1;
	assign qz = hz_s1 * nz_s1;

	assign m2_sum = {2'b00, sqx_s2} + {2'b00, sqy_s2} + {2'b00, sqz_s2};
	assign d_sum  = {{2{dx_s2[31]}}, dx_s2} + {{2{dy_s2[31]}}, dy_s2}
		+ {{2{dz_s2[31]}}, dz_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hx_s1 <= {light_dir_x[15], light_dir_x} - {view_dir_x[15], view_dir_x};
			hy_s1 <= {light_dir_y[15], light_dir_y} - {view_dir_y[15], view_dir_y};
			hz_s1 <= {light_dir_z[15], light_dir_z} - {view_dir_z[15], view_dir_z};
			nx_s1 <= normal_x;
			ny_s1 <= normal_y;
			nz_s1 <= normal_z;
			side_s1.zero     <= 1'b0;
			side_s1.strength <= spec_strength;
			side_s1.exponent <= spec_exponent;
			side_s1.rgb      <= light_rgb;

			sqx_s2  <= px[31:0];
			sqy_s2  <= py[31:0];
			sqz_s2  <= pz[31:0];
			dx_s2   <= qx[31:0];
			dy_s2   <= qy[31:0];
			dz_s2   <= qz[31:0];
			side_s2 <= side_s1;

			m2_s3 <= m2_sum;
			d_s3  <= d_sum;
			side_s3.zero     <= (m2_sum == '0);
			side_s3.strength <= side_s2.strength;
			side_s3.exponent <= side_s2.exponent;
			side_s3.rgb      <= side_s2.rgb;
		end
	end

	assign fr_valid = vld_s3;
	assign fr_m2    = m2_s3;
	assign fr_d     = d_s3;
	assign fr_side  = side_s3;

endmodule

`default_nettype wire

>>> src/bps_sqrt.sv
`default_nettype none

module bps_sqrt
	import bps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic        [33:0] m2,
	input  logic signed [33:0] d,
	input  side_t              side,
	output logic               sq_valid,
	output logic        [26:0] sq_root,
	output logic signed [33:0] sq_d,
	output side_t              sq_side
);

	logic                   vld_s  [SQ_STEPS];
	logic [SQ_W-1:0]        rem_s  [SQ_STEPS];
	logic [SQ_W-1:0]        root_s [SQ_STEPS];
	logic signed [33:0]     d_s    [SQ_STEPS];
	side_t                  side_s [SQ_STEPS];

	// One result bit per stage, restoring method on m2 * 2^20
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
		localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
		logic               vld_in;
		logic [SQ_W-1:0]    rem_in, root_in, trial;
		logic signed [33:0] d_in;
		side_t              side_in;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = {{(SQ_W - 54){1'b0}}, m2, 20'b0};
			assign root_in = '0;
			assign d_in    = d;
			assign side_in = side;
		end else begin : g_next
			assign vld_in  = vld_s[k - 1];
			assign rem_in  = rem_s[k - 1];
			assign root_in = root_s[k - 1];
			assign d_in    = d_s[k - 1];
			assign side_in = side_s[k - 1];
		end

		assign trial = root_in + BITV;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (rem_in >= trial) begin
					rem_s[k]  <= rem_in - trial;
					root_s[k] <= (root_in >> 1) + BITV;
				end else begin
					rem_s[k]  <= rem_in;
					root_s[k] <= root_in >> 1;
				end
				d_s[k]    <= d_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign sq_valid = vld_s[SQ_STEPS - 1];
	assign sq_root  = root_s[SQ_STEPS - 1][26:0];
	assign sq_d     = d_s[SQ_STEPS - 1];
	assign sq_side  = side_s[SQ_STEPS - 1];

endmodule

`default_nettype wire

>>> src/bps_div.sv
`default_nettype none

module bps_div
	import bps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  logic        [26:0] root,
	input  logic signed [33:0] d,
	input  side_t              side,
	output logic               dv_valid,
	output logic        [16:0] dv_cos,
	output side_t              dv_side
);

	logic              vld_s0;
	logic              pos_s0, cap_s0;
	logic [DIV_W-1:0]  rem_s0;
	logic [26:0]       den_s0;
	side_t             side_s0;

	logic              vld_s  [DIV_STEPS];
	logic              pos_s  [DIV_STEPS];
	logic              cap_s  [DIV_STEPS];
	logic [DIV_W-1:0]  rem_s  [DIV_STEPS];
	logic [26:0]       den_s  [DIV_STEPS];
	logic [15:0]       quo_s  [DIV_STEPS];
	side_t             side_s [DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= in_valid;
		end
	end

	// Quotient of 2^16 or more: cap at one
	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s0  <= !d[33] && (d != '0);
			cap_s0  <= {1'b0, d[32:0]} >= {3'b000, root, 4'b0000};
			rem_s0  <= {d[32:0], 12'b0};
			den_s0  <= root;
			side_s0 <= side;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int SH = DIV_STEPS - 1 - k;
		logic             vld_in, pos_in, cap_in;
		logic [DIV_W-1:0] rem_in, trial;
		logic [26:0]      den_in;
		logic [15:0]      quo_in;
		side_t            side_in;

		if (k == 0) begin : g_first
			assign vld_in  = vld_s0;
			assign pos_in  = pos_s0;
			assign cap_in  = cap_s0;
			assign rem_in  = rem_s0;
			assign den_in  = den_s0;
			assign quo_in  = '0;
			assign side_in = side_s0;
		end else begin : g_next
			assign vld_in  = vld_s[k - 1];
			assign pos_in  = pos_s[k - 1];
			assign cap_in  = cap_s[k - 1];
			assign rem_in  = rem_s[k - 1];
			assign den_in  = den_s[k - 1];
			assign quo_in  = quo_s[k - 1];
			assign side_in = side_s[k - 1];
		end

		assign trial = {{(DIV_W - 27){1'b0}}, den_in} << SH;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					quo_s[k] <= quo_in | (16'd1 << SH);
				end else begin
					rem_s[k] <= rem_in;
					quo_s[k] <= quo_in;
				end
				pos_s[k]  <= pos_in;
				cap_s[k]  <= cap_in;
				den_s[k]  <= den_in;
				side_s[k] <= side_in;
			end
		end
	end

	always_comb begin
		if (!pos_s[DIV_STEPS - 1]) begin
			dv_cos = '0;
		end else if (cap_s[DIV_STEPS - 1]) begin
			dv_cos = ONE_Q16;
		end else begin
			dv_cos = {1'b0, quo_s[DIV_STEPS - 1]};
		end
	end

	assign dv_valid = vld_s[DIV_STEPS - 1];
	assign dv_side  = side_s[DIV_STEPS - 1];

endmodule

`default_nettype wire

>>> src/bps_pow.sv
`default_nettype none

module bps_pow
	import bps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_valid,
	input  logic [16:0] cos,
	input  side_t       side,
	output logic        out_valid,
	output logic [15:0] add_red,
	output logic [15:0] add_green,
	output logic [15:0] add_blue
);

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [16:0] c_s1;
	logic [4:0]  p_s1;
	logic        e0_s1, c0_s1, e0_s2, c0_s2, e0_s3, c0_s3;
	side_t       side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [20:0] nl_s2;
	logic [28:0] t_s3;
	logic [16:0] pw_s4;
	logic [32:0] term_s5;
	logic [24:0] xr_s6, xg_s6, xb_s6;
	logic [15:0] red_s7, green_s7, blue_s7;

	logic [4:0]                top_bit;
	logic [4:0]                shamt;
	logic [16:0]               cnorm;
	logic [POW_TABLE_BITS-1:0] lg_idx;
	logic [15:0]               lg_val;
	logic [20:0]               base;
	logic [20:0]               nl;
	logic [36:0]               t_full;
	logic [12:0]               q;
	logic [POW_TABLE_BITS-1:0] ex_idx;
	logic [16:0]               pw;
	logic [40:0]               pr, pg, pb;
	logic [50:0]               yr, yg, yb;

	always_comb begin
		top_bit = '0;
		for (int i = 1; i < 17; i++) begin
			if (cos[i]) begin
				top_bit = 5'(i);
			end
		end
	end

	// -log2(cos) = (16 - p) - log2(mantissa)
	assign shamt  = 5'd16 - p_s1;
	assign cnorm  = c_s1 << shamt;
	assign lg_idx = cnorm[15 -: POW_TABLE_BITS];
	assign lg_val = LG_TAB[lg_idx];
	assign base   = {shamt, 16'b0};
	assign nl     = (base > {5'b0, lg_val}) ? base - {5'b0, lg_val} : '0;

	assign t_full = {16'b0, nl_s2} * {21'b0, side_s2.exponent};

	assign q      = t_s3[28:16];
	assign ex_idx = t_s3[15 -: POW_TABLE_BITS];

	always_comb begin
		if (side_s3.zero) begin
			pw = '0;
		end else if (e0_s3) begin
			pw = ONE_Q16;
		end else if (c0_s3 || (q > 13'd16)) begin
			pw = '0;
		end else begin
			pw = EX_TAB[ex_idx] >> q[4:0];
		end
	end

	assign pr = {8'b0, term_s5} * {33'b0, side_s5.rgb[23:16]};
	assign pg = {8'b0, term_s5} * {33'b0, side_s5.rgb[15:8]};
	assign pb = {8'b0, term_s5} * {33'b0, side_s5.rgb[7:0]};

	assign yr = {26'b0, xr_s6} * {25'b0, RECIP_255};
	assign yg = {26'b0, xg_s6} * {25'b0, RECIP_255};
	assign yb = {26'b0, xb_s6} * {25'b0, RECIP_255};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1    <= cos;
			p_s1    <= top_bit;
			e0_s1   <= (side.exponent == '0);
			c0_s1   <= (cos == '0);
			side_s1 <= side;

			nl_s2   <= nl;
			e0_s2   <= e0_s1;
			c0_s2   <= c0_s1;
			side_s2 <= side_s1;

			t_s3    <= t_full[36:8];
			e0_s3   <= e0_s2;
			c0_s3   <= c0_s2;
			side_s3 <= side_s2;

			pw_s4   <= pw;
			side_s4 <= side_s3;

			term_s5 <= {17'b0, side_s4.strength} * {16'b0, pw_s4};
			side_s5 <= side_s4;

			xr_s6 <= pr[40:16];
			xg_s6 <= pg[40:16];
			xb_s6 <= pb[40:16];

			red_s7   <= (yr[50:33] > 18'd65535) ? 16'hFFFF : yr[48:33];
			green_s7 <= (yg[50:33] > 18'd65535) ? 16'hFFFF : yg[48:33];
			blue_s7  <= (yb[50:33] > 18'd65535) ? 16'hFFFF : yb[48:33];
		end
	end

	assign out_valid = vld_s7;
	assign add_red   = red_s7;
	assign add_green = green_s7;
	assign add_blue  = blue_s7;

endmodule

`default_nettype wire

>>> tb/sv/bps_scoreboard.sv
`default_nettype none

module bps_scoreboard
	import bps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [15:0] light_dir_x,
	input  logic signed [15:0] light_dir_y,
	input  logic signed [15:0] light_dir_z,
	input  logic signed [15:0] view_dir_x,
	input  logic signed [15:0] view_dir_y,
	input  logic signed [15:0] view_dir_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic        [15:0] spec_strength,
	input  logic        [15:0] spec_exponent,
	input  logic        [23:0] light_rgb,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic        [15:0] add_red,
	input  logic        [15:0] add_green,
	input  logic        [15:0] add_blue,
	output int                 errors,
	output int                 in_count,
	output int                 out_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} color_add_t;

	logic [15:0] log2_rom [TBL_SIZE];
	logic [16:0] exp2_rom [TBL_SIZE];
	color_add_t  color_q [$];

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned v;
		longint unsigned r;
		longint unsigned b;
		v = x;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	initial begin
		longint unsigned roots [POW_TABLE_BITS + 1];
		longint unsigned y;
		longint unsigned prod;
		logic [15:0] bits;
		roots[0] = 0;
		roots[1] = int_sqrt(64'd1 << 63);
		for (int k = 2; k <= POW_TABLE_BITS; k++)
			roots[k] = int_sqrt(roots[k - 1] << 32);
		for (int i = 0; i < TBL_SIZE; i++) begin
			// square the mantissa, shift out one log bit per round
			y = longint'(TBL_SIZE + i) << (30 - POW_TABLE_BITS);
			bits = '0;
			for (int k = 0; k < 16; k++) begin
				y = (y * y) >> 30;
				bits = {bits[14:0], 1'b0};
				if (y >= (64'd1 << 31)) begin
					bits[0] = 1'b1;
					y = y >> 1;
				end
			end
			log2_rom[i] = bits;
			prod = 64'd1 << 32;
			for (int k = 1; k <= POW_TABLE_BITS; k++)
				if (((i >> (POW_TABLE_BITS - k)) & 1) != 0)
					prod = (prod * roots[k]) >> 32;
			exp2_rom[i] = 17'((prod + 64'd32768) >> 16);
		end
	end

	function automatic longint unsigned cos_power(input longint unsigned c,
			input longint unsigned e);
		int p;
		longint unsigned idx;
		longint unsigned nl;
		longint unsigned t;
		longint unsigned q;
		if (e == 0) return 65536;
		if (c == 0) return 0;
		p = 16;
		while (p > 0 && ((c >> p) & 1) == 0) p--;
		if (p >= POW_TABLE_BITS) idx = (c >> (p - POW_TABLE_BITS)) & (TBL_SIZE - 1);
		else idx = (c << (POW_TABLE_BITS - p)) & (TBL_SIZE - 1);
		nl = longint'(16 - p) * 65536;
		nl = (nl > log2_rom[idx]) ? nl - log2_rom[idx] : 0;
		t = (nl * e) >> 8;
		q = t >> 16;
		if (q > 16) return 0;
		return exp2_rom[((t & 16'hFFFF) >> (16 - POW_TABLE_BITS)) & (TBL_SIZE - 1)] >> q;
	endfunction

	function automatic color_add_t shade(
			input logic signed [15:0] lx, ly, lz, vx, vy, vz, nx, ny, nz,
			input logic [15:0] strength, exponent, input logic [23:0] rgb);
		color_add_t res;
		longint hx, hy, hz, d;
		longint unsigned m2, s, c, term, v;
		hx = longint'(lx) - longint'(vx);
		hy = longint'(ly) - longint'(vy);
		hz = longint'(lz) - longint'(vz);
		res = '{16'd0, 16'd0, 16'd0};
		m2 = hx * hx + hy * hy + hz * hz;
		if (m2 == 0) return res;
		d = hx * longint'(nx) + hy * longint'(ny) + hz * longint'(nz);
		s = int_sqrt(m2 << 20);
		if (d <= 0 || s == 0) c = 0;
		else begin
			c = (longint'(d) << 12) / s;
			if (c > 65536) c = 65536;
		end
		term = longint'(strength) * cos_power(c, exponent);
		v = term * rgb[23:16] / (255 * 65536);
		res.red = (v > 65535) ? 16'hFFFF : 16'(v);
		v = term * rgb[15:8] / (255 * 65536);
		res.green = (v > 65535) ? 16'hFFFF : 16'(v);
		v = term * rgb[7:0] / (255 * 65536);
		res.blue = (v > 65535) ? 16'hFFFF : 16'(v);
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		color_add_t want;
		int bad;
		if (!arst_n) begin
			errors <= 0;
			in_count <= 0;
			out_count <= 0;
		end else begin
			bad = 0;
			if (in_valid && !in_stall) begin
				color_q.push_back(shade(light_dir_x, light_dir_y, light_dir_z,
					view_dir_x, view_dir_y, view_dir_z, normal_x, normal_y, normal_z,
					spec_strength, spec_exponent, light_rgb));
				in_count <= in_count + 1;
			end
			if (out_valid && !out_stall) begin
				out_count <= out_count + 1;
				if (color_q.size() == 0) begin
					$error("result transfer with nothing expected");
					bad++;
				end else begin
					want = color_q.pop_front();
					if (add_red !== want.red) begin
						$error("add_red: expected %0d, got %0d", want.red, add_red);
						bad++;
					end
					if (add_green !== want.green) begin
						$error("add_green: expected %0d, got %0d", want.green, add_green);
						bad++;
					end
					if (add_blue !== want.blue) begin
						$error("add_blue: expected %0d, got %0d", want.blue, add_blue);
						bad++;
					end
				end
			end
			errors <= errors + bad;
		end
	end

endmodule

`default_nettype wire

>>> tb/sv/blinn_phong_specular_shader_core_tb.sv
`default_nettype none

module blinn_phong_specular_shader_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1250;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 3000;
	localparam logic signed [15:0] ONE = 16'sd16384;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] light_dir_x = '0, light_dir_y = '0, light_dir_z = '0;
	logic signed [15:0] view_dir_x = '0, view_dir_y = '0, view_dir_z = '0;
	logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic        [15:0] spec_strength = '0, spec_exponent = '0;
	logic        [23:0] light_rgb = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic        [15:0] add_red, add_green, add_blue;
	int                 errors, in_count, out_count;
	bit                 hold_req = 1'b0;
	int                 burst_left = 0;

	always #5 clk = ~clk;

	blinn_phong_specular_shader_core i_dut (.*);

	bps_scoreboard i_scoreboard (.*);

	task automatic send(input logic signed [15:0] lx, ly, lz, vx, vy, vz, nx, ny, nz,
			input logic [15:0] strength, exponent, input logic [23:0] rgb);
		int gap;
		int target;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		light_dir_x <= lx; light_dir_y <= ly; light_dir_z <= lz;
		view_dir_x <= vx; view_dir_y <= vy; view_dir_z <= vz;
		normal_x <= nx; normal_y <= ny; normal_z <= nz;
		spec_strength <= strength;
		spec_exponent <= exponent;
		light_rgb <= rgb;
		in_valid <= 1'b1;
		target = in_count + 1;
		do @(negedge clk); while (in_count < target);
	endtask

	task automatic unit_vec(output logic signed [15:0] x, y, z);
		real a, b, c, n;
		a = real'(int'($urandom_range(0, 32768)) - 16384);
		b = real'(int'($urandom_range(0, 32768)) - 16384);
		c = real'(int'($urandom_range(0, 32768)) - 16384);
		n = $sqrt(a * a + b * b + c * c);
		if (n < 1.0) begin
			a = 16384.0;
			n = 16384.0;
		end
		x = 16'($rtoi(a * 16384.0 / n));
		y = 16'($rtoi(b * 16384.0 / n));
		z = 16'($rtoi(c * 16384.0 / n));
	endtask

	task automatic send_random();
		logic signed [15:0] lx, ly, lz, vx, vy, vz, nx, ny, nz;
		logic [15:0] ex;
		real hx, hy, hz, n;
		int kind;
		kind = $urandom_range(0, 9);
		unit_vec(lx, ly, lz);
		unit_vec(vx, vy, vz);
		unit_vec(nx, ny, nz);
		if (kind <= 1) begin
			{lx, ly, lz, vx, vy, vz} = {$urandom, $urandom, $urandom};
			{nx, ny, nz} = 48'({$urandom, $urandom});
		end else if (kind == 2) begin
			// equal light and view: zero half vector
			{vx, vy, vz} = {lx, ly, lz};
		end else if (kind >= 6) begin
			// normal near the half vector, so the highlight is strong
			hx = real'(lx) - real'(vx) + real'(int'($urandom_range(0, 4000)) - 2000);
			hy = real'(ly) - real'(vy) + real'(int'($urandom_range(0, 4000)) - 2000);
			hz = real'(lz) - real'(vz) + real'(int'($urandom_range(0, 4000)) - 2000);
			n = $sqrt(hx * hx + hy * hy + hz * hz);
			if (n >= 1.0) begin
				nx = 16'($rtoi(hx * 16384.0 / n));
				ny = 16'($rtoi(hy * 16384.0 / n));
				nz = 16'($rtoi(hz * 16384.0 / n));
			end
		end
		case ($urandom_range(0, 3))
			0: ex = 16'($urandom);
			1: ex = 16'($urandom_range(0, 16'h0400));
			default: ex = 16'($urandom_range(0, 16'h4000));
		endcase
		send(lx, ly, lz, vx, vy, vz, nx, ny, nz, 16'($urandom), ex, 24'($urandom));
	endtask

	// receiver: stall pattern switches among random modes: never, rarely or mostly stalled
	initial begin
		int mode;
		int tick;
		mode = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else begin
				if (tick % 64 == 0) mode = $urandom_range(0, 2);
				tick++;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// watchdog on transfers
	initial begin
		int idle;
		int last_in;
		int last_out;
		idle = 0;
		last_in = 0;
		last_out = 0;
		forever begin
			@(negedge clk);
			if (in_count != last_in || out_count != last_out) idle = 0;
			else idle++;
			last_in = in_count;
			last_out = out_count;
			if (idle >= IDLE_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("blinn_phong_specular_shader_core_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero half vector
		send(ONE, 0, 0, ONE, 0, 0, ONE, 0, 0, 16'h0100, 16'h1000, 24'hFFFFFF);
		send(0, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF, 16'h0000, 24'hFFFFFF);
		// aligned normal, cosine one
		send(ONE, 0, 0, -ONE, 0, 0, ONE, 0, 0, 16'h0100, 16'h0100, 24'hFFFFFF);
		send(0, ONE, 0, 0, -ONE, 0, 0, ONE, 0, 16'hFFFF, 16'h2000, 24'hFF8001);
		// negative cosine, with and without zero exponent
		send(ONE, 0, 0, -ONE, 0, 0, -ONE, 0, 0, 16'h0100, 16'h0800, 24'hFFFFFF);
		send(ONE, 0, 0, -ONE, 0, 0, -ONE, 0, 0, 16'h0100, 16'h0000, 24'hFFFFFF);
		// cosine exactly zero
		send(ONE, 0, 0, -ONE, 0, 0, 0, ONE, 0, 16'h0100, 16'h0000, 24'h808080);
		send(ONE, 0, 0, -ONE, 0, 0, 0, 0, ONE, 16'h0100, 16'h0100, 24'h808080);
		// zero exponent, positive cosine
		send(ONE, ONE, 0, 0, 0, -ONE, 0, ONE, 0, 16'h0300, 16'h0000, 24'h123456);
		// extreme field values, not unit length
		send(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
		send(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
			16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 16'h0001, 24'hFFFFFF);
		send(16'sh7FFF, 16'sh8000, 0, 16'sh8000, 16'sh7FFF, 0,
			16'sh7FFF, 16'sh8000, 0, 16'hFFFF, 16'h0000, 24'hFFFFFF);
		// half-angle cases, and tiny half vectors, at a range of exponents
		send(ONE, 0, 0, 0, ONE, 0, ONE, 0, 0, 16'h0100, 16'h0100, 24'hFF0000);
		send(ONE, 0, 0, 0, ONE, 0, ONE, 0, 0, 16'h0100, 16'h2000, 24'h00FF00);
		send(ONE, 0, 0, 0, ONE, 0, ONE, 0, 0, 16'h0100, 16'hFFFF, 24'h0000FF);
		send(ONE, 0, 0, 0, ONE, 0, ONE, 16'sh8000, 0, 16'h0001, 16'h0080, 24'h000000);
		send(1, 0, 0, 0, 0, 0, 1, 0, 0, 16'h8000, 16'h0040, 24'h7F7F7F);
		send(0, 0, 1, 0, 0, -1, 0, 0, ONE, 16'h0100, 16'h0100, 24'hFFFFFF);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 400) hold_req = 1'b1;
			if (i == 800) begin
				in_valid <= 1'b0;
				while (in_count != out_count) @(negedge clk);
			end
			send_random();
		end
		in_valid <= 1'b0;

		while (in_count != out_count) @(negedge clk);
		repeat (80) @(negedge clk);
		$display("shaded %0d samples (directed extremes, zero half vectors, random",
			in_count);
		$display("unit and raw vectors) and checked %0d results", out_count);
		if (errors == 0) begin
			$display("blinn_phong_specular_shader_core_tb: done, clean");
		end else begin
			$display("blinn_phong_specular_shader_core_tb: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+src
src/bps_pkg.sv
src/bps_front.sv
src/bps_sqrt.sv
src/bps_div.sv
src/bps_pow.sv
src/blinn_phong_specular_shader_core.sv
tb/sv/bps_scoreboard.sv
tb/sv/blinn_phong_specular_shader_core_tb.sv
